// ===== rtl/core/hsi_pkg.sv =====
// Shared types and constants for the two-level hash index.
// Used by hsi_ctrl, hsi_dpath and the top level; depends on nothing.
package hsi_pkg;

	localparam int LEAF_ENTRIES = 64;
	localparam int LIDX_W       = $clog2(LEAF_ENTRIES);
	localparam int CNT_W        = LIDX_W + 1;
	localparam int LADDR_W      = 2 * LIDX_W;
	localparam int SPLIT_POINT  = (LEAF_ENTRIES + 1) / 2;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_FOUND    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] chunk;
	} leaf_word_t;

	typedef struct packed {
		logic [31:0]       key;
		logic [LIDX_W-1:0] id;
	} root_word_t;

	typedef enum logic [4:0] {
		UOP_NONE, UOP_CLR, UOP_ACCEPT, UOP_RT_RD, UOP_RT_CMP, UOP_ID_RD,
		UOP_LID_LOAD, UOP_SC_RD, UOP_SC_CMP, UOP_SPL_INIT, UOP_CP_RD,
		UOP_CP_WR, UOP_RS_INIT, UOP_RS_RD, UOP_RS_WR, UOP_RT_NEW,
		UOP_SH_INIT, UOP_SH_RD, UOP_SH_WR, UOP_SH_PUT, UOP_EMIT_OK,
		UOP_EMIT_NOSP, UOP_LK_HIT, UOP_LK_NEXT, UOP_EMIT_LAST
	} uop_t;

	typedef struct packed {
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_lookup;
		logic reject;
		logic r_end;
		logic ge;
		logic j_last;
		logic full;
		logic split_ok;
		logic q_ge_r;
		logic j_gt_i;
		logic brk;
		logic match;
		logic cand_v;
		logic out_free;
	} stat_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_RT_RD, S_RT_CMP, S_ID_RD, S_ID_WAIT,
		S_SC_RD, S_SC_CMP, S_SPL_CHK, S_CP_RD, S_CP_WR, S_RS_INIT, S_RS_CHK,
		S_RS_WR, S_RT_NEW, S_SH_INIT, S_SH_CHK, S_SH_WR, S_SH_PUT, S_OK,
		S_NOSPACE, S_LK_RD, S_LK_CMP, S_LK_END
	} state_t;

endpackage

// ===== rtl/core/hsi_ctrl.sv =====
// Sequencer for the hash index: walks root, scans leaves, splits and shifts.
// Depends on hsi_pkg; drives micro-ops into hsi_dpath.
module hsi_ctrl import hsi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and micro-op
	always_comb begin
		state_d  = state_q;
		cmd.uop  = UOP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.uop = UOP_CLR;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.uop = UOP_ACCEPT;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!st.is_lookup && st.reject) state_d = S_NOSPACE;
				else state_d = S_RT_RD;
			end
			// root walk
			S_RT_RD: begin
				if (st.r_end) begin
					state_d = S_ID_RD;
				end else begin
					cmd.uop = UOP_RT_RD;
					state_d = S_RT_CMP;
				end
			end
			S_RT_CMP: begin
				cmd.uop = UOP_RT_CMP;
				state_d = st.ge ? S_RT_RD : S_ID_RD;
			end
			S_ID_RD: begin
				cmd.uop = UOP_ID_RD;
				state_d = S_ID_WAIT;
			end
			S_ID_WAIT: begin
				cmd.uop = UOP_LID_LOAD;
				state_d = st.is_lookup ? S_LK_RD : S_SC_RD;
			end
			// insert: scan whole leaf
			S_SC_RD: begin
				cmd.uop = UOP_SC_RD;
				state_d = S_SC_CMP;
			end
			S_SC_CMP: begin
				cmd.uop = UOP_SC_CMP;
				state_d = st.j_last ? S_SPL_CHK : S_SC_RD;
			end
			S_SPL_CHK: begin
				if (!st.full) begin
					state_d = S_SH_INIT;
				end else if (!st.split_ok) begin
					state_d = S_NOSPACE;
				end else begin
					cmd.uop = UOP_SPL_INIT;
					state_d = S_CP_RD;
				end
			end
			// split: move upper part to the new leaf
			S_CP_RD: begin
				cmd.uop = UOP_CP_RD;
				state_d = S_CP_WR;
			end
			S_CP_WR: begin
				cmd.uop = UOP_CP_WR;
				state_d = st.j_last ? S_RS_INIT : S_CP_RD;
			end
			S_RS_INIT: begin
				cmd.uop = UOP_RS_INIT;
				state_d = S_RS_CHK;
			end
			S_RS_CHK: begin
				if (st.q_ge_r) begin
					cmd.uop = UOP_RS_RD;
					state_d = S_RS_WR;
				end else begin
					state_d = S_RT_NEW;
				end
			end
			S_RS_WR: begin
				cmd.uop = UOP_RS_WR;
				state_d = S_RS_CHK;
			end
			S_RT_NEW: begin
				cmd.uop = UOP_RT_NEW;
				state_d = S_SH_INIT;
			end
			// open a slot and place the word
			S_SH_INIT: begin
				cmd.uop = UOP_SH_INIT;
				state_d = S_SH_CHK;
			end
			S_SH_CHK: begin
				if (st.j_gt_i) begin
					cmd.uop = UOP_SH_RD;
					state_d = S_SH_WR;
				end else begin
					state_d = S_SH_PUT;
				end
			end
			S_SH_WR: begin
				cmd.uop = UOP_SH_WR;
				state_d = S_SH_CHK;
			end
			S_SH_PUT: begin
				cmd.uop = UOP_SH_PUT;
				state_d = S_OK;
			end
			S_OK: begin
				if (st.out_free) begin
					cmd.uop = UOP_EMIT_OK;
					state_d = S_IDLE;
				end
			end
			S_NOSPACE: begin
				if (st.out_free) begin
					cmd.uop = UOP_EMIT_NOSP;
					state_d = S_IDLE;
				end
			end
			// lookup scan
			S_LK_RD: begin
				cmd.uop = UOP_SC_RD;
				state_d = S_LK_CMP;
			end
			S_LK_CMP: begin
				if (st.brk) begin
					state_d = S_LK_END;
				end else if (st.match) begin
					if (!st.cand_v || st.out_free) begin
						cmd.uop = UOP_LK_HIT;
						state_d = st.j_last ? S_LK_END : S_LK_RD;
					end
				end else begin
					cmd.uop = UOP_LK_NEXT;
					state_d = st.j_last ? S_LK_END : S_LK_RD;
				end
			end
			S_LK_END: begin
				if (st.out_free) begin
					cmd.uop = UOP_EMIT_LAST;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

// ===== rtl/core/hsi_dpath.sv =====
// Datapath of the hash index: root and leaf memories, indexes, result register.
// Depends on hsi_pkg; executes micro-ops from hsi_ctrl.
module hsi_dpath import hsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic        operation,
	input  logic [31:0] key_hash,
	input  logic [31:0] chunk_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] found_chunk,
	output logic        last
);

	leaf_word_t leaf_mem [LEAF_ENTRIES*LEAF_ENTRIES];
	root_word_t root_mem [LEAF_ENTRIES];

	// control registers
	logic [LADDR_W-1:0] clr_q;
	logic [CNT_W-1:0]   lcnt_q;
	logic               out_valid_q;
	// working registers
	logic               op_q;
	logic [31:0]        key_q, chunk_q, prev_q, nkey_q, cand_q;
	logic [CNT_W-1:0]   r_q, j_q, i_q;
	logic [LIDX_W-1:0]  lid_q, s_q, hi_q, lo_q;
	logic               ifound_q, full_q, hi_v_q, lo_v_q, cand_v_q;
	leaf_word_t         lrd_q;
	root_word_t         rrd_q;
	logic [1:0]         status_q;
	logic [31:0]        fchunk_q;
	logic               last_q;

	// memory port controls
	logic               lw_en, lr_en, rw_en, rr_en;
	logic [LADDR_W-1:0] lw_addr, lr_addr;
	logic [LIDX_W-1:0]  rw_addr, rr_addr;
	leaf_word_t         lw_data;
	root_word_t         rw_data;

	logic [LIDX_W-1:0]  jj;
	logic               out_free, brk;

	assign jj       = j_q[LIDX_W-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign brk      = (lrd_q.chunk == 32'd0) || (key_q < lrd_q.key);

	// status to the sequencer
	always_comb begin
		st.clr_done  = (clr_q == {LADDR_W{1'b1}});
		st.is_lookup = op_q;
		st.reject    = (chunk_q == 32'd0) || (lcnt_q == CNT_W'(LEAF_ENTRIES));
		st.r_end     = (r_q >= lcnt_q);
		st.ge        = !(key_q < rrd_q.key);
		st.j_last    = (jj == {LIDX_W{1'b1}});
		st.full      = full_q;
		st.split_ok  = hi_v_q || lo_v_q;
		st.q_ge_r    = (j_q >= r_q);
		st.j_gt_i    = (j_q > i_q);
		st.brk       = brk;
		st.match     = (lrd_q.key == key_q);
		st.cand_v    = cand_v_q;
		st.out_free  = out_free;
	end

	// memory port selection
	always_comb begin
		lw_en   = 1'b0;
		lr_en   = 1'b0;
		rw_en   = 1'b0;
		rr_en   = 1'b0;
		lw_addr = {lid_q, jj};
		lr_addr = {lid_q, jj};
		rw_addr = r_q[LIDX_W-1:0];
		rr_addr = r_q[LIDX_W-1:0];
		lw_data = lrd_q;
		rw_data = rrd_q;
		unique case (cmd.uop)
			UOP_CLR: begin
				lw_en   = 1'b1;
				lw_addr = clr_q;
				lw_data = '0;
				rw_en   = 1'b1;
				rw_addr = '0;
				rw_data = '0;
			end
			UOP_RT_RD: rr_en = 1'b1;
			UOP_ID_RD: begin
				rr_en   = 1'b1;
				rr_addr = LIDX_W'(r_q - CNT_W'(1));
			end
			UOP_SC_RD: lr_en = 1'b1;
			UOP_CP_RD: begin
				lr_en   = 1'b1;
				lw_en   = 1'b1;
				lw_data = '0;
			end
			UOP_CP_WR: begin
				lw_en   = 1'b1;
				lw_addr = {lcnt_q[LIDX_W-1:0], LIDX_W'(jj - s_q)};
			end
			UOP_RS_RD: begin
				rr_en   = 1'b1;
				rr_addr = jj;
			end
			UOP_RS_WR: begin
				rw_en   = 1'b1;
				rw_addr = LIDX_W'(jj + LIDX_W'(1));
			end
			UOP_RT_NEW: begin
				rw_en   = 1'b1;
				rw_data = '{key: nkey_q, id: lcnt_q[LIDX_W-1:0]};
			end
			UOP_SH_RD: begin
				lr_en   = 1'b1;
				lr_addr = {lid_q, LIDX_W'(jj - LIDX_W'(1))};
			end
			UOP_SH_WR: lw_en = 1'b1;
			UOP_SH_PUT: begin
				lw_en   = 1'b1;
				lw_addr = {lid_q, i_q[LIDX_W-1:0]};
				lw_data = '{key: key_q, chunk: chunk_q};
			end
			default: ;
		endcase
	end

	// leaf memory, read-before-write
	always_ff @(posedge clk) begin
		if (lw_en) leaf_mem[lw_addr] <= lw_data;
		if (lr_en) lrd_q <= leaf_mem[lr_addr];
	end

	// root memory
	always_ff @(posedge clk) begin
		if (rw_en) root_mem[rw_addr] <= rw_data;
		if (rr_en) rrd_q <= root_mem[rr_addr];
	end

	// control state: clear pass, leaf count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			lcnt_q      <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.uop == UOP_CLR) clr_q <= clr_q + LADDR_W'(1);
			if (cmd.uop == UOP_RT_NEW) lcnt_q <= lcnt_q + CNT_W'(1);
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.uop == UOP_EMIT_OK || cmd.uop == UOP_EMIT_NOSP ||
			    cmd.uop == UOP_EMIT_LAST || (cmd.uop == UOP_LK_HIT && cand_v_q))
				out_valid_q <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_ACCEPT: begin
				op_q    <= operation;
				key_q   <= key_hash;
				chunk_q <= chunk_number;
				r_q     <= CNT_W'(1);
			end
			UOP_RT_CMP: if (!(key_q < rrd_q.key)) r_q <= r_q + CNT_W'(1);
			UOP_ID_RD: begin
				j_q      <= '0;
				i_q      <= CNT_W'(LEAF_ENTRIES);
				ifound_q <= 1'b0;
				full_q   <= 1'b0;
				hi_v_q   <= 1'b0;
				lo_v_q   <= 1'b0;
				cand_v_q <= 1'b0;
			end
			UOP_LID_LOAD: lid_q <= rrd_q.id;
			UOP_SC_CMP: begin
				if (!ifound_q && brk) begin
					i_q      <= j_q;
					ifound_q <= 1'b1;
				end
				if (jj == {LIDX_W{1'b1}}) full_q <= (lrd_q.chunk != 32'd0);
				// split candidates: first change at or above the middle,
				// last change below it
				if (jj != '0 && lrd_q.key != prev_q) begin
					if (jj >= LIDX_W'(SPLIT_POINT)) begin
						if (!hi_v_q) begin
							hi_q   <= jj;
							hi_v_q <= 1'b1;
						end
					end else begin
						lo_q   <= jj;
						lo_v_q <= 1'b1;
					end
				end
				prev_q <= lrd_q.key;
				j_q    <= j_q + CNT_W'(1);
			end
			UOP_SPL_INIT: begin
				s_q <= hi_v_q ? hi_q : lo_q;
				j_q <= {1'b0, (hi_v_q ? hi_q : lo_q)};
			end
			UOP_CP_WR: begin
				if (jj == s_q) nkey_q <= lrd_q.key;
				j_q <= j_q + CNT_W'(1);
			end
			UOP_RS_INIT: j_q <= lcnt_q - CNT_W'(1);
			UOP_RS_WR: j_q <= j_q - CNT_W'(1);
			UOP_RT_NEW: begin
				if (i_q > {1'b0, s_q}) begin
					lid_q <= lcnt_q[LIDX_W-1:0];
					i_q   <= i_q - {1'b0, s_q};
				end
			end
			UOP_SH_INIT: j_q <= CNT_W'(LEAF_ENTRIES - 1);
			UOP_SH_WR: j_q <= j_q - CNT_W'(1);
			UOP_LK_HIT: begin
				cand_q   <= lrd_q.chunk;
				cand_v_q <= 1'b1;
				j_q      <= j_q + CNT_W'(1);
			end
			UOP_LK_NEXT: j_q <= j_q + CNT_W'(1);
			default: ;
		endcase
	end

	// result word register
	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_EMIT_OK: begin
				status_q <= ST_INSERTED;
				fchunk_q <= 32'd0;
				last_q   <= 1'b1;
			end
			UOP_EMIT_NOSP: begin
				status_q <= ST_NOSPACE;
				fchunk_q <= 32'd0;
				last_q   <= 1'b1;
			end
			UOP_LK_HIT: begin
				if (cand_v_q) begin
					status_q <= ST_FOUND;
					fchunk_q <= cand_q;
					last_q   <= 1'b0;
				end
			end
			UOP_EMIT_LAST: begin
				status_q <= cand_v_q ? ST_FOUND : ST_NOTFOUND;
				fchunk_q <= cand_v_q ? cand_q : 32'd0;
				last_q   <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_chunk = fchunk_q;
	assign last        = last_q;

endmodule

// ===== rtl/core/two_level_hash_index.sv =====
// Top level of the two-level hash index: sequencer plus datapath.
// Depends on hsi_pkg, hsi_ctrl and hsi_dpath.
//
//   channel | signals                                   | dir
//   in      | in_valid, in_ready, operation, key_hash,  | word in
//           | chunk_number                              |
//   out     | out_valid, out_ready, status,             | word out
//           | found_chunk, last                         |
//
// After reset a clearing pass writes all 4096 leaf slots with in_ready low.
// One word is worked at a time, all through one leaf memory port pair: the
// route reads each root slot passed, a lookup reads leaf slots up to an
// empty slot or a larger key, an insert scans the whole leaf, moves the upper
// slots and shifts root slots on split, then shifts leaf slots. A stalled out
// channel holds the lookup scan; the next word is taken while a result waits.
module two_level_hash_index import hsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] key_hash,
	input  logic [31:0] chunk_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] found_chunk,
	output logic        last
);

	cmd_t  cmd;
	stat_t st;

	hsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	hsi_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.operation    (operation),
		.key_hash     (key_hash),
		.chunk_number (chunk_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_chunk  (found_chunk),
		.last         (last)
	);

endmodule

// ===== rtl/core/hsi_checker.sv =====
// Port-level checks for two_level_hash_index, bound onto the top level.
// Depends on hsi_pkg for status codes.
module hsi_checker import hsi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] found_chunk,
	input logic        last
);

	// a result word held back stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// one word in flight: busy right after accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// insert answers are single and final
	a_ins_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_INSERTED || status == ST_NOSPACE) |-> last)
		else $error("insert answer without last");

	// only candidates carry a chunk, and never an empty one
	a_chunk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> found_chunk == 32'd0)
		else $error("chunk on a non-candidate word");

	a_cand_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FOUND |-> found_chunk != 32'd0)
		else $error("candidate with empty chunk");

endmodule

bind two_level_hash_index hsi_checker u_hsi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found_chunk (found_chunk),
	.last        (last)
);

// ===== bench/testbench.sv =====
// Testbench for the two-level hash index: directed and random insert/lookup words.
// Depends on hsi_pkg and two_level_hash_index; predicts results with its own index copy.
module testbench;
	import hsi_pkg::*;

	localparam int NLEAF = LEAF_ENTRIES;
	localparam int HALF  = (NLEAF + 1) / 2;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] key;
		logic [31:0] chunk;
	} word_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] chunk;
		logic        fin;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [31:0] key_hash = '0;
	logic [31:0] chunk_number = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] found_chunk;
	logic        last;

	two_level_hash_index dut (.*);

	always #10 clk = ~clk;

	// index copy
	int          n_leaves;
	logic [31:0] rt_key [NLEAF];
	int          rt_id  [NLEAF];
	logic [31:0] lf_key [NLEAF*NLEAF];
	logic [31:0] lf_chk [NLEAF*NLEAF];

	word_t   pending_words[$];
	result_t expected_results[$];
	logic [31:0] used_keys[$];
	int      errors = 0;
	int      send_idle = 21, recv_idle = 54;
	bit      hold_out = 1'b0;

	function automatic int pick_slot(logic [31:0] key);
		int r;
		r = 1;
		while (r < n_leaves && r < NLEAF && !(key < rt_key[r]))
			r++;
		return r;
	endfunction

	function automatic bit index_insert(logic [31:0] key, logic [31:0] chk);
		int r, i, s, n, nid, base, nbase;
		bit ok;
		ok = 1'b0;
		if (chk == 0)
			return 1'b0;
		r = pick_slot(key);
		if (n_leaves >= NLEAF)
			return 1'b0;
		base = rt_id[r-1] * NLEAF;
		for (i = 0; i < NLEAF; i++)
			if (lf_chk[base+i] == 0 || key < lf_key[base+i])
				break;
		// full leaf: split keeping equal-key runs together
		if (lf_chk[base+NLEAF-1] != 0) begin
			for (s = HALF; s < NLEAF; s++)
				if (lf_key[base+s] != lf_key[base+s-1]) begin
					ok = 1'b1;
					break;
				end
			if (!ok)
				for (s = HALF - 1; s > 0; s--)
					if (lf_key[base+s] != lf_key[base+s-1]) begin
						ok = 1'b1;
						break;
					end
			if (!ok)
				return 1'b0;
			nid = n_leaves;
			nbase = nid * NLEAF;
			n = NLEAF - s;
			for (int k = 0; k < NLEAF; k++) begin
				lf_key[nbase+k] = (k < n) ? lf_key[base+s+k] : 32'd0;
				lf_chk[nbase+k] = (k < n) ? lf_chk[base+s+k] : 32'd0;
			end
			for (int k = s; k < NLEAF; k++) begin
				lf_key[base+k] = 0;
				lf_chk[base+k] = 0;
			end
			for (int k = n_leaves; k > r; k--) begin
				rt_key[k] = rt_key[k-1];
				rt_id[k] = rt_id[k-1];
			end
			rt_key[r] = lf_key[nbase];
			rt_id[r] = nid;
			n_leaves++;
			if (i > s) begin
				base = nbase;
				i -= s;
			end
		end
		for (int k = NLEAF - 1; k > i; k--) begin
			lf_key[base+k] = lf_key[base+k-1];
			lf_chk[base+k] = lf_chk[base+k-1];
		end
		lf_key[base+i] = key;
		lf_chk[base+i] = chk;
		return 1'b1;
	endfunction

	task automatic predict_word(word_t w);
		int base, cnt;
		result_t res;
		if (w.op == OP_INSERT) begin
			res.st = index_insert(w.key, w.chunk) ? ST_INSERTED : ST_NOSPACE;
			res.chunk = '0;
			res.fin = 1'b1;
			expected_results.push_back(res);
			return;
		end
		base = rt_id[pick_slot(w.key) - 1] * NLEAF;
		cnt = 0;
		for (int i = 0; i < NLEAF; i++) begin
			if (lf_chk[base+i] == 0 || w.key < lf_key[base+i])
				break;
			if (lf_key[base+i] == w.key) begin
				res.st = ST_FOUND;
				res.chunk = lf_chk[base+i];
				res.fin = 1'b0;
				expected_results.push_back(res);
				cnt++;
			end
		end
		if (cnt == 0) begin
			res.st = ST_NOTFOUND;
			res.chunk = '0;
			res.fin = 1'b1;
			expected_results.push_back(res);
		end else
			expected_results[$].fin = 1'b1;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		word_t w;
		if (in_valid && in_ready) begin
			predict_word('{operation, key_hash, chunk_number});
		end
		if (!in_valid || in_ready) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle
					&& arst_n) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				operation <= w.op;
				key_hash <= w.key;
				chunk_number <= w.chunk;
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0)
				report_mismatch("unexpected word", {30'd0, status}, 0);
			else begin
				e = expected_results.pop_front();
				if (status != e.st)
					report_mismatch("status", {30'd0, status}, {30'd0, e.st});
				if (found_chunk != e.chunk)
					report_mismatch("found_chunk", found_chunk, e.chunk);
				if (last != e.fin)
					report_mismatch("last", {31'd0, last}, {31'd0, e.fin});
			end
		end
		out_ready <= !hold_out && ($urandom_range(99) >= recv_idle);
	end

	function automatic word_t make_word(logic op, logic [31:0] key, logic [31:0] chk);
		word_t w;
		w.op = op;
		w.key = key;
		w.chunk = chk;
		return w;
	endfunction

	function automatic logic [31:0] pick_key();
		if (used_keys.size() > 0 && $urandom_range(99) < 60)
			return used_keys[$urandom_range(used_keys.size() - 1)];
		return $urandom();
	endfunction

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		logic [31:0] k;
		for (int n = 0; n < count; n++) begin
			k = pick_key();
			used_keys.push_back(k);
			if ($urandom_range(99) < 55)
				pending_words.push_back(make_word(OP_INSERT, k,
					($urandom_range(99) < 3) ? 32'd0 : ($urandom() | 32'd1)));
			else
				pending_words.push_back(make_word(OP_LOOKUP, k, $urandom()));
		end
	endtask

	initial begin
		n_leaves = 1;
		for (int i = 0; i < NLEAF; i++) begin
			rt_key[i] = 0;
			rt_id[i] = 0;
		end
		for (int i = 0; i < NLEAF*NLEAF; i++) begin
			lf_key[i] = 0;
			lf_chk[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero chunk, empty lookups, equal-key run
		pending_words.push_back(make_word(OP_LOOKUP, 32'h0, 32'h0));
		pending_words.push_back(make_word(OP_INSERT, 32'h0, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(OP_INSERT, 32'hFFFF_FFFF, 32'h1));
		pending_words.push_back(make_word(OP_INSERT, 32'h5555_5555, 32'h0));
		pending_words.push_back(make_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'hAAAA_AAAA));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h0, 32'h0));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h5555_5555, 32'h0));
		for (int i = 0; i < 6; i++)
			pending_words.push_back(make_word(OP_INSERT, 32'hAAAA_AAAA, 32'h100 + i));
		pending_words.push_back(make_word(OP_LOOKUP, 32'hAAAA_AAAA, 32'h0));
		used_keys.push_back(32'hAAAA_AAAA);
		// pause until everything has come back
		drain();

		// a key filling a whole leaf: lookup gives the maximum result count,
		// further inserts hit the no-split-point case
		for (int i = 0; i < NLEAF + 2; i++)
			pending_words.push_back(make_word(OP_INSERT, 32'h8000_0000, i + 1));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h8000_0000, 32'h0));
		// receiver holds off while the sender keeps offering
		hold_out = 1'b1;
		repeat (3000) @(posedge clk);
		hold_out = 1'b0;
		drain();

		random_phase(70);
		drain();
		send_idle = 54;
		recv_idle = 21;
		random_phase(70);
		drain();
		send_idle = 0;
		recv_idle = 0;
		// distinct keys spread over the leaves
		for (int n = 0; n < 20; n++)
			pending_words.push_back(make_word(OP_INSERT, $urandom(), $urandom() | 32'd1));
		random_phase(40);
		drain();

		if (errors == 0)
			$display("[two_level_hash_index] OK");
		else
			$display("[two_level_hash_index] ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("[two_level_hash_index] ERROR");
		$finish;
	end
endmodule

// ===== two_level_hash_index.f =====
rtl/core/hsi_pkg.sv
rtl/core/hsi_ctrl.sv
rtl/core/hsi_dpath.sv
rtl/core/two_level_hash_index.sv
rtl/core/hsi_checker.sv
bench/testbench.sv
